// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mexp_pkg: shared types for the modular exponentiation block
// Control word handed from the sequencer to the row of multiplier cells.
// -----------------------------------------------------------------------------
package mexp_pkg;

   // One step of a shift-add multiplication, broadcast to every cell.
   typedef struct packed {
      logic start;   // clear accumulator, load operands
      logic step;    // do one double-and-add step
   } mul_ctrl_type;

endpackage

// ===== rtl/mexp_mulcell.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mexp_mulcell: one modular shift-add multiplier cell
// Computes a*b mod m one multiplier bit per cycle while step is high, MSB first.
// -----------------------------------------------------------------------------
module mexp_mulcell #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mexp_pkg::mul_ctrl_type ctrl,
   input  logic [WIDTH-1:0]      a_in,
   input  logic [WIDTH-1:0]      b_in,
   input  logic [WIDTH-1:0]      modulus,
   output logic [WIDTH-1:0]      product
);

   logic [WIDTH-1:0] a_ff, a_next_in;
   logic [WIDTH-1:0] b_ff, b_next_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH:0]   dbl, dbl_red, sum;
   logic [WIDTH-1:0] dbl_w;

   // double then conditionally add, each reduced by one compare-subtract
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      dbl_w   = dbl_red[WIDTH-1:0];
      sum     = {1'b0, dbl_w} + {1'b0, a_ff};
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      acc_in    = b_ff[WIDTH-1] ? sum[WIDTH-1:0] : dbl_w;
      a_next_in = a_ff;
      b_next_in = {b_ff[WIDTH-2:0], 1'b0};
      if (ctrl.start) begin
         acc_in    = '0;
         a_next_in = a_in;
         b_next_in = b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.start || ctrl.step) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start || ctrl.step) begin
         a_ff <= a_next_in;
         b_ff <= b_next_in;
      end
   end

   assign product = acc_ff;

endmodule

// ===== rtl/mexp_reduce.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mexp_reduce: bit-serial base reduction
// Computes x mod m by restoring remainder, one bit a cycle while step is high.
// -----------------------------------------------------------------------------
module mexp_reduce #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             step,
   input  logic [WIDTH-1:0] x_in,
   input  logic [WIDTH-1:0] modulus,
   output logic [WIDTH-1:0] remainder
);

   logic [WIDTH-1:0] r_ff, r_in, x_ff, x_next_in;
   logic [WIDTH:0]   sh;

   always_comb begin
      sh     = {r_ff, x_ff[WIDTH-1]};
      if (sh >= {1'b0, modulus}) begin
         sh = sh - {1'b0, modulus};
      end
      r_in      = sh[WIDTH-1:0];
      x_next_in = {x_ff[WIDTH-2:0], 1'b0};
      if (start) begin
         r_in      = '0;
         x_next_in = x_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;
      end else if (start || step) begin
         r_ff <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start || step) begin
         x_ff <= x_next_in;
      end
   end

   assign remainder = r_ff;

endmodule

// ===== rtl/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// modular_exponentiation_top: base^exponent mod modulus
// Right-to-left square-and-multiply over two shift-add multiplier cells.
// -----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word carries base (low WIDTH bits) and exponent.
//   rsp_ channel: one word carries power_mod, the result.
//   csr_: write modulus with csr_we; write only while idle. Reset value 2.
// Sequence: the base is reduced first, then WIDTH rounds each load the two
//   multiplier cells and run square and multiply side by side in them;
//   a final state picks the last product into the output register.
// Flow: one item in flight; req_tready is high only while idle, so the
//   next word is taken at the earliest once the result is out.
// A result may wait in the output register while the next word is worked on;
//   if it still waits when the next result is ready, hold the sequencer until
//   the receiver takes it. A stalled receiver holds rsp_tdata until taken.
// Reset returns the sequencer to idle, drops any pending result and loads
//   modulus 2. A modulus below 2 returns 0.
// -----------------------------------------------------------------------------
module modular_exponentiation_top #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2*WIDTH-1:0]   req_tdata,   // base, exponent
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [WIDTH-1:0]     rsp_tdata,   // power_mod
   input  logic                 csr_we,
   input  logic [WIDTH-1:0]     csr_wdata    // modulus
);

   localparam int CW = $clog2(WIDTH + 2);
   localparam int EW = $clog2(WIDTH + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RED  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_NEXT = 2'd3;

   logic [WIDTH-1:0] modulus_ff;
   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [EW-1:0]    round_ff, round_in;
   logic [WIDTH-1:0] exp_ff, acc_ff;
   logic             last_bit_ff;
   logic             rsp_valid_ff;
   logic [WIDTH-1:0] rsp_data_ff;
   logic             accept;
   logic             red_start, red_step;
   logic             mul_last, final_round, out_free, finish;
   mexp_pkg::mul_ctrl_type mctrl;
   logic [WIDTH-1:0] red_out, sq_out, mu_out;
   logic [WIDTH-1:0] base_next, acc_next;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign red_start   = accept;
   assign red_step    = (state_ff == ST_RED);
   assign mul_last    = (state_ff == ST_MUL) && (cnt_ff == CW'(WIDTH - 1));
   assign final_round = (round_ff == EW'(WIDTH));
   assign out_free    = !rsp_valid_ff || rsp_tready;
   // final load cycle: hand the result over once the output register is free
   assign finish      = (state_ff == ST_NEXT) && final_round && out_free;

   // operands of the coming round: the reduced base first, then the products
   // of the round just finished; take the multiply only when its bit was set
   assign base_next = (round_ff == '0) ? red_out : sq_out;
   assign acc_next  = (round_ff != '0 && last_bit_ff) ? mu_out : acc_ff;

   // load both cells at the head of each round, then step them together
   always_comb begin
      mctrl.start = (state_ff == ST_NEXT) && !final_round;
      mctrl.step  = (state_ff == ST_MUL);
   end

   mexp_reduce #(.WIDTH(WIDTH)) u_reduce (
      .clock, .reset, .start(red_start), .step(red_step),
      .x_in(req_tdata[WIDTH-1:0]), .modulus(modulus_ff), .remainder(red_out)
   );

   // squaring cell
   mexp_mulcell #(.WIDTH(WIDTH)) u_square (
      .clock, .reset, .ctrl(mctrl), .a_in(base_next), .b_in(base_next),
      .modulus(modulus_ff), .product(sq_out)
   );

   // multiply cell
   mexp_mulcell #(.WIDTH(WIDTH)) u_mult (
      .clock, .reset, .ctrl(mctrl), .a_in(acc_next), .b_in(base_next),
      .modulus(modulus_ff), .product(mu_out)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      round_in = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RED;
               cnt_in   = '0;
            end
         end
         ST_RED: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(WIDTH - 1)) begin
               state_in = ST_NEXT;
               round_in = '0;
            end
         end
         ST_NEXT: begin
            if (final_round) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_MUL;
               cnt_in   = '0;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(WIDTH - 1)) begin
               round_in = round_ff + 1'b1;
               state_in = ST_NEXT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         round_ff     <= '0;
         modulus_ff   <= WIDTH'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         round_ff <= round_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // datapath: latch the accumulator each round, advance the exponent
   always_ff @(posedge clock) begin
      if (accept) begin
         exp_ff <= req_tdata[2*WIDTH-1:WIDTH];
         acc_ff <= WIDTH'(1);
      end
      if (state_ff == ST_NEXT && !final_round) begin
         acc_ff <= acc_next;
      end
      if (mul_last) begin
         exp_ff      <= {1'b0, exp_ff[WIDTH-1:1]};
         last_bit_ff <= exp_ff[0];
      end
      if (finish) begin
         rsp_data_ff <= (modulus_ff < WIDTH'(2)) ? '0 : acc_next;
      end
   end

endmodule

// ===== tb/modular_exponentiation_top_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// modular_exponentiation_top_tb: self-checking bench for modular exponentiation
// Streams base/exponent words into the block under several moduli and compares
// every power_mod word with a bit-exact predictor built on 64-bit arithmetic.
// Idling on both sides follows three phases; the modulus changes between them.
// -----------------------------------------------------------------------------
module modular_exponentiation_top_tb;

   localparam int WIDTH      = 32;
   localparam int LATENCY    = WIDTH * (WIDTH + 2) + 2;
   localparam int LIMIT      = 3000000;
   localparam int NUM_RANDOM = 270;

   typedef struct packed {
      logic [WIDTH-1:0] exponent;
      logic [WIDTH-1:0] base;
   } exp_req_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [2*WIDTH-1:0] req_tdata;   // base, exponent
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [WIDTH-1:0] rsp_tdata;     // power_mod
   logic             csr_we;
   logic [WIDTH-1:0] csr_wdata;     // modulus

   modular_exponentiation_top #(.WIDTH(WIDTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   exp_req_type      pending_words[$];
   logic [WIDTH-1:0] expected_powers[$];
   logic [WIDTH-1:0] modulus_shadow;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               error_count;
   int               result_count;
   int               cycle_count;
   int               words_sent;

   // (a * b) mod m on a double-width product; a, b < m
   function automatic logic [WIDTH-1:0] mul_mod(logic [WIDTH-1:0] a,
                                                 logic [WIDTH-1:0] b,
                                                 logic [WIDTH-1:0] m);
      logic [2*WIDTH-1:0] prod;
      prod = {{WIDTH{1'b0}}, a} * {{WIDTH{1'b0}}, b};
      return WIDTH'(prod % {{WIDTH{1'b0}}, m});
   endfunction

   // base^exponent mod m, right to left square-and-multiply
   function automatic logic [WIDTH-1:0] power_mod(logic [WIDTH-1:0] base,
                                                   logic [WIDTH-1:0] exponent,
                                                   logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] acc;
      logic [WIDTH-1:0] sq;
      if (m < WIDTH'(2)) return '0;
      sq  = base % m;
      acc = WIDTH'(1);
      for (int i = 0; i < WIDTH; i++) begin
         if (exponent[i]) acc = mul_mod(acc, sq, m);
         sq = mul_mod(sq, sq, m);
      end
      return acc;
   endfunction

   // Sender side, sampled on the rising edge: pop on accept, predict result.
   logic send_hold;
   logic req_taken;
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         expected_powers.insert(expected_powers.size(),
                                power_mod(req_tdata[WIDTH-1:0],
                                          req_tdata[2*WIDTH-1:WIDTH],
                                          modulus_shadow));
         void'(pending_words.pop_front());
         words_sent++;
         req_taken = 1'b1;
      end
   end

   // Driver, falling edge: hold a waiting word, else choose the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && !req_taken) begin
            // word still waiting; keep valid and data steady
         end else if (pending_words.size() != 0 && !send_hold &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_words[0];
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: compare each result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("modular_exponentiation_top_tb: errors");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_powers.size() == 0) begin
               $error("power_mod: unexpected word, actual %0h", rsp_tdata);
               error_count++;
            end else begin
               if (rsp_tdata !== expected_powers[0]) begin
                  $error("power_mod: expected %0h actual %0h",
                         expected_powers[0], rsp_tdata);
                  error_count++;
               end
               void'(expected_powers.pop_front());
            end
         end
      end
   end

   task automatic queue_word(logic [WIDTH-1:0] base, logic [WIDTH-1:0] exponent);
      exp_req_type w;
      w.base     = base;
      w.exponent = exponent;
      pending_words.insert(pending_words.size(), w);
   endtask

   // Wait until all words are out and every result is back, then settle.
   task automatic drain();
      wait (pending_words.size() == 0 && !req_tvalid);
      wait (expected_powers.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   // Write the modulus while idle, at a falling edge for one cycle.
   task automatic set_modulus(logic [WIDTH-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      modulus_shadow = value;
   endtask

   // Random words: mostly random operands, some small or all-ones exponents, edge bases.
   task automatic queue_random(int count);
      logic [WIDTH-1:0] b, e;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(5))
            0:       b = '1;
            1:       b = modulus_shadow + $urandom_range(3);
            default: b = $urandom;
         endcase
         case ($urandom_range(4))
            0:       e = $urandom_range(15);
            1:       e = '1;
            default: e = $urandom;
         endcase
         queue_word(b, e);
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      send_hold     = 1'b0;
      send_idle_pct = 13;
      recv_idle_pct = 62;
      error_count   = 0;
      result_count  = 0;
      cycle_count   = 0;
      words_sent    = 0;
      modulus_shadow = 2;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset modulus 2: base extremes, exponent zero, base zero.
      queue_word('0, '0);
      queue_word('0, 5);
      queue_word('1, '1);
      queue_word(3, 0);
      drain();

      // Largest modulus: extremes of base and exponent.
      set_modulus('1);
      queue_word('1, 1);
      queue_word('1 - 1, 2);
      queue_word(32'h8000_0000, '1);
      queue_word(32'h7FFF_FFFF, 32'hAAAA_AAAA);
      queue_word('0, '0);
      queue_word(2, 31);
      drain();

      // Moduli below two return zero.
      set_modulus(0);
      queue_word(7, 0);
      queue_word(5, 3);
      drain();
      set_modulus(1);
      queue_word(7, 0);
      queue_word('1, '1);
      drain();

      // Prime modulus: Fermat case and base equal to the modulus.
      set_modulus(32'd4294967291);
      queue_word(12345, 32'd4294967290);
      queue_word(32'd4294967291, 9);
      queue_word(32'd4294967292, 3);
      queue_word(5, 32'h5555_5555);
      drain();

      // Phase 1: sender idles lightly, receiver stalls often.
      set_modulus($urandom | 32'h8000_0000);
      queue_random(NUM_RANDOM / 3);
      // Pause the sender until the pipeline drains, then resume.
      wait (pending_words.size() < NUM_RANDOM / 6);
      send_hold = 1'b1;
      wait (!req_tvalid && expected_powers.size() == 0);
      send_hold = 1'b0;
      drain();

      // Phase 2: roles swapped, small modulus.
      send_idle_pct = 62;
      recv_idle_pct = 13;
      set_modulus($urandom_range(1000, 2));
      queue_random(NUM_RANDOM / 3);
      drain();

      // Phase 3: no idling, random full-range modulus.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_modulus($urandom_range(32'hFFFF_FFFF, 2));
      queue_random(NUM_RANDOM - 2 * (NUM_RANDOM / 3));
      drain();

      $display("Sent %0d words over eight modulus settings, %0d results checked.",
               words_sent, result_count);
      $display("Covered moduli 0, 1, 2, small, prime and all-ones with edge operands.");
      if (error_count == 0 && expected_powers.size() == 0) begin
         $display("modular_exponentiation_top_tb: clean");
      end else begin
         $display("modular_exponentiation_top_tb: errors");
      end
      $finish;
   end

endmodule
